[sv/imf_pkg.sv]
// ----------------------------------------------------------------------------
// imf_pkg
// Shared types, constants and MD5 tables for the folded MD5 checksum core.
// ----------------------------------------------------------------------------
package imf_pkg;

    localparam int ZERO_WINDOW_DEF = 512;
    localparam int SKIP_BYTES_DEF  = 4;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [0:0] REG_WINDOW_MODE   = 1'd0;
    localparam logic [0:0] REG_KERNEL_OFFSET = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_SUM,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       take_byte;  // write the input byte (if hashed)
        logic       pad_byte;   // write one padding byte
        logic       round;      // run one MD5 round
        logic       fold;       // add working vars into chain
        logic       sum;        // fold digest into checksum
        logic       restart;    // reload IV and clear counters
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       block_full; // current write completes a block
        logic       round_last; // round counter at 63
        logic       pad_done;   // padding reached end of message
    } t_stat;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
        };
        return k[i];
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;
            4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;
            4'd14: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0:    g = i[3:0];
            2'd1:    g = 4'(5 * i[3:0] + 1);
            2'd2:    g = 4'(3 * i[3:0] + 5);
            default: g = 4'(7 * i[3:0]);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

[sv/imf_datapath.sv]
// ----------------------------------------------------------------------------
// imf_datapath
// Block buffer, byte counters, one shared MD5 round unit and checksum fold.
// ----------------------------------------------------------------------------
module imf_datapath import imf_pkg::*; #(
    parameter int ZERO_WINDOW = ZERO_WINDOW_DEF,
    parameter int SKIP_BYTES  = SKIP_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic        i_window_mode,
    input  logic [31:0] i_kernel_offset,
    output t_stat       o_stat,
    output logic [31:0] o_checksum
);

    logic [31:0] r_buf [16];
    logic [31:0] r_a, r_b, r_c, r_d;   // working variables
    logic [31:0] r_h0, r_h1, r_h2, r_h3;
    logic [31:0] r_hashed, r_pos, r_len;
    logic [5:0]  r_round;
    logic [31:0] r_sum;
    logic [5:0]  r_pad_idx;
    logic        r_pad_first;
    logic        r_len_blk;            // length field lands in this padding block

    logic        hash_it;
    logic [7:0]  eff_byte;
    logic [32:0] rel;
    logic [5:0]  wr_idx;
    logic [7:0]  wr_byte;
    logic        wr_en;
    logic [63:0] bit_len;
    logic [31:0] f, t, rot;
    logic [4:0]  s;
    logic [5:0]  pad_start;

    // window decision for the incoming byte
    always_comb begin
        rel      = {1'b0, r_pos} - {1'b0, i_kernel_offset};
        hash_it  = 1'b1;
        eff_byte = i_data_byte;
        if (i_window_mode) begin
            if ({1'b0, r_pos} < 33'(SKIP_BYTES)) begin
                hash_it = 1'b0;
            end else if (!rel[32] && rel[31:0] < 32'(ZERO_WINDOW)) begin
                eff_byte = 8'h00;
            end
        end
    end

    assign bit_len   = {29'd0, r_len, 3'd0};
    assign pad_start = r_hashed[5:0] + (hash_it ? 6'd1 : 6'd0);

    always_comb begin
        wr_idx  = r_hashed[5:0];
        wr_byte = eff_byte;
        wr_en   = i_cmd.take_byte && hash_it;
        if (i_cmd.pad_byte) begin
            wr_idx = r_pad_idx;
            wr_en  = 1'b1;
            if (r_pad_first) begin
                wr_byte = 8'h80;
            end else if (r_len_blk && r_pad_idx >= 6'd56) begin
                wr_byte = bit_len[{r_pad_idx[2:0], 3'd0} +: 8];
            end else begin
                wr_byte = 8'h00;
            end
        end
    end

    assign o_stat.block_full = wr_en && (wr_idx == 6'd63);
    assign o_stat.round_last = (r_round == 6'd63);
    assign o_stat.pad_done   = i_cmd.pad_byte && (r_pad_idx == 6'd63) && r_len_blk;

    // MD5 round
    always_comb begin
        case (r_round[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_d & r_b) | (~r_d & r_c);
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        s   = rot_amt(r_round);
        t   = r_a + f + round_k(r_round) + r_buf[msg_index(r_round)];
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[wr_idx[5:2]][{wr_idx[1:0], 3'd0} +: 8] <= wr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_h0 <= IV_A; r_h1 <= IV_B; r_h2 <= IV_C; r_h3 <= IV_D;
            r_a  <= IV_A; r_b  <= IV_B; r_c  <= IV_C; r_d  <= IV_D;
            r_hashed    <= '0;
            r_pos       <= '0;
            r_round     <= '0;
            r_pad_first <= 1'b1;
            r_pad_idx   <= '0;
            r_len_blk   <= 1'b0;
        end else begin
            if (i_cmd.take_byte) begin
                if (hash_it) r_hashed <= r_hashed + 32'd1;
                if (r_pos != 32'hFFFF_FFFF) r_pos <= r_pos + 32'd1;
                // latch length and padding start for a possible finish
                r_len     <= r_hashed + (hash_it ? 32'd1 : 32'd0);
                r_pad_idx <= pad_start;
                r_len_blk <= (pad_start < 6'd56);
            end
            if (i_cmd.pad_byte) begin
                r_pad_first <= 1'b0;
                r_pad_idx   <= r_pad_idx + 6'd1;
                if (r_pad_idx == 6'd63) r_len_blk <= 1'b1;
            end
            if (i_cmd.round) begin
                r_a <= r_d; r_d <= r_c; r_c <= r_b;
                r_b <= r_b + rot;
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.fold) begin
                r_h0 <= r_h0 + r_a; r_h1 <= r_h1 + r_b;
                r_h2 <= r_h2 + r_c; r_h3 <= r_h3 + r_d;
                r_a  <= r_h0 + r_a; r_b  <= r_h1 + r_b;
                r_c  <= r_h2 + r_c; r_d  <= r_h3 + r_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sum <= bswap(r_h0) + bswap(r_h1) + bswap(r_h2) + bswap(r_h3);
        end
    end

    assign o_checksum = (r_sum == 32'd0) ? 32'd1 : r_sum;

endmodule

[sv/imf_ctrl.sv]
// ----------------------------------------------------------------------------
// imf_ctrl
// Sequencer: byte intake, 64 rounds per block, padding and result handoff.
// ----------------------------------------------------------------------------
module imf_ctrl import imf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_last,
    output logic  o_stall,
    output logic  o_valid,
    input  logic  i_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_final, n_final;   // last item taken, padding phase
    logic   r_done_pad;         // padding reached the length field

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

    always_comb begin
        n_state = r_state;
        n_final = r_final;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.take_byte = 1'b1;
                    n_final = i_last;
                    if (i_stat.block_full) begin
                        n_state = ST_ROUND;
                    end else if (i_last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_stat.round_last) n_state = ST_FOLD;
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                if (r_done_pad) begin
                    n_state = ST_SUM;
                end else if (r_final) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                o_cmd.pad_byte = 1'b1;
                if (i_stat.block_full) n_state = ST_ROUND;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    o_cmd.restart = 1'b1;
                    n_final = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_cmd.restart) begin
            r_done_pad <= 1'b0;
        end else if (i_stat.pad_done) begin
            r_done_pad <= 1'b1;
        end
    end

endmodule

[sv/image_md5_folded_checksum_core.sv]
// ----------------------------------------------------------------------------
// image_md5_folded_checksum_core
// Folded MD5 checksum of an image streamed one byte per item.
// ----------------------------------------------------------------------------
// Input: bytes are taken while idle; each 64th hashed byte closes a block
//   and holds o_stall for its 64 rounds on the single round unit and the
//   chain update. Finish: a block closed by the last item is compressed;
//   padding is written one byte a cycle (up to 72 bytes), each padding block
//   (one or two) is compressed, then a sum step runs; the result is held until
//   taken. Reset (synchronous, active low) loads the MD5 IV, clears counters
//   and the window mode; block buffer, length and sum are not cleared.
module image_md5_folded_checksum_core import imf_pkg::*; #(
    parameter int ZERO_WINDOW = ZERO_WINDOW_DEF,
    parameter int SKIP_BYTES  = SKIP_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_checksum,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cmd        cmd;
    t_stat       stat;
    logic        r_window_mode;
    logic [31:0] r_kernel_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_mode   <= 1'b0;
            r_kernel_offset <= 32'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WINDOW_MODE:   r_window_mode   <= i_cfg_data[0];
                REG_KERNEL_OFFSET: r_kernel_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    imf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    imf_datapath #(
        .ZERO_WINDOW (ZERO_WINDOW),
        .SKIP_BYTES  (SKIP_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_data_byte     (i_data_byte),
        .i_window_mode   (r_window_mode),
        .i_kernel_offset (r_kernel_offset),
        .o_stat          (stat),
        .o_checksum      (o_checksum)
    );

    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid |-> o_stall)) else $error("input taken while result pending");

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid |-> o_checksum != 32'd0)) else $error("zero checksum");

    a_restart_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall |=> !o_valid)) else $error("result repeated");

endmodule
